[design/rvx_pkg.sv]
// Shared types, command and status codes and default sizes for the register VM execute unit.
package rvx_pkg;

	localparam int NUM_REGS_DEF  = 16;
	localparam int MEM_WORDS_DEF = 256;

	localparam int WORD_W     = 16;
	localparam int CMD_W      = 3;
	localparam int REG_FLD_W  = 4;
	localparam int ADDR_FLD_W = 8;
	localparam int STATUS_W   = 2;

	localparam logic [CMD_W-1:0] CMD_ADD      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_MOVE_REG = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MOVE_IMM = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LOAD     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_STORE    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ_REG = 3'd5;
	localparam logic [CMD_W-1:0] CMD_READ_MEM = 3'd6;

	localparam logic [STATUS_W-1:0] ST_SILENT   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_VALID    = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd2;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		logic  reg_we;
		word_t reg_wdata;
		logic  mem_we;
		word_t mem_wdata;
	} wb_t;

endpackage

[design/register_vm_execute_unit.sv]
// Top level of the register VM execute unit: input stage, register file, data memory, result register.
// A taken command is registered in the input stage, executed, then held in the result register.
// Throughput: one command per cycle unless busy; the write-back is bypassed into the next reads.
// Reset clears control at once, then a clearing pass zeroes the register file and data memory
// while busy is high.
// Results cannot be held off: each appears for one cycle under strobe.
module register_vm_execute_unit #(
	parameter int NUM_REGS  = rvx_pkg::NUM_REGS_DEF,
	parameter int MEM_WORDS = rvx_pkg::MEM_WORDS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [rvx_pkg::CMD_W-1:0]      cmd,
	input  logic [rvx_pkg::REG_FLD_W-1:0]  dest_reg,
	input  logic [rvx_pkg::REG_FLD_W-1:0]  src_reg,
	input  logic [rvx_pkg::ADDR_FLD_W-1:0] mem_addr,
	input  logic [rvx_pkg::WORD_W-1:0]     immediate,
	output logic                           strobe,
	output logic [rvx_pkg::WORD_W-1:0]     value,
	output logic [rvx_pkg::STATUS_W-1:0]   status
);

	localparam int RW        = $clog2(NUM_REGS);
	localparam int MW        = $clog2(MEM_WORDS);
	localparam int CLR_DEPTH = (NUM_REGS > MEM_WORDS) ? NUM_REGS : MEM_WORDS;
	localparam int CW        = $clog2(CLR_DEPTH);
	localparam int REG_CODES = 2 ** rvx_pkg::REG_FLD_W;
	localparam int MEM_CODES = 2 ** rvx_pkg::ADDR_FLD_W;

	logic [RW-1:0] reg_wrap [REG_CODES];
	logic [MW-1:0] mem_wrap [MEM_CODES];

	genvar gi;
	generate
		for (gi = 0; gi < REG_CODES; gi++) begin : g_reg_wrap
			localparam int RIDX = gi % NUM_REGS;
			assign reg_wrap[gi] = RW'(RIDX);
		end
		for (gi = 0; gi < MEM_CODES; gi++) begin : g_mem_wrap
			localparam int MIDX = gi % MEM_WORDS;
			assign mem_wrap[gi] = MW'(MIDX);
		end
	endgenerate

	logic          clearing_q;
	logic [CW-1:0] clr_q;
	logic          accept;

	logic                         valid_s1;
	logic [rvx_pkg::CMD_W-1:0]    cmd_s1;
	logic [RW-1:0]                d_idx_s1;
	logic [MW-1:0]                a_idx_s1;
	rvx_pkg::word_t               imm_s1;
	rvx_pkg::word_t               rd_d_s1;
	rvx_pkg::word_t               rd_s_s1;
	rvx_pkg::word_t               mrd_s1;

	logic [RW-1:0] d_idx;
	logic [RW-1:0] s_idx;
	logic [MW-1:0] a_idx;

	rvx_pkg::word_t               ex_value;
	logic [rvx_pkg::STATUS_W-1:0] ex_status;
	rvx_pkg::wb_t                 wb;

	logic           reg_we;
	logic [RW-1:0]  reg_waddr;
	rvx_pkg::word_t reg_wdata;
	logic           mem_we;
	logic [MW-1:0]  mem_waddr;
	rvx_pkg::word_t mem_wdata;

	rvx_pkg::word_t regs [NUM_REGS];
	rvx_pkg::word_t mem  [MEM_WORDS];

	logic           strobe_q;
	rvx_pkg::word_t value_q;
	logic [rvx_pkg::STATUS_W-1:0] status_q;

	assign busy   = clearing_q;
	assign accept = start & ~clearing_q;

	assign d_idx = reg_wrap[dest_reg];
	assign s_idx = reg_wrap[src_reg];
	assign a_idx = mem_wrap[mem_addr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			if (clr_q == CW'(CLR_DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd;
			d_idx_s1 <= d_idx;
			a_idx_s1 <= a_idx;
			imm_s1   <= immediate;
		end
	end

	rvx_exec u_exec (
		.cmd       (cmd_s1),
		.immediate (imm_s1),
		.reg_d     (rd_d_s1),
		.reg_s     (rd_s_s1),
		.mem_rd    (mrd_s1),
		.value     (ex_value),
		.status    (ex_status),
		.wb        (wb)
	);

	always_comb begin
		if (clearing_q) begin
			reg_we    = 1'b1;
			reg_waddr = clr_q[RW-1:0];
			reg_wdata = '0;
			mem_we    = 1'b1;
			mem_waddr = clr_q[MW-1:0];
			mem_wdata = '0;
		end else begin
			reg_we    = valid_s1 & wb.reg_we;
			reg_waddr = d_idx_s1;
			reg_wdata = wb.reg_wdata;
			mem_we    = valid_s1 & wb.mem_we;
			mem_waddr = a_idx_s1;
			mem_wdata = wb.mem_wdata;
		end
	end

	// The command in the execute stage writes back at the same edge as the next reads,
	// so a matching address takes the write data instead of the stored word.
	always_ff @(posedge clk) begin
		if (reg_we) begin
			regs[reg_waddr] <= reg_wdata;
		end
		rd_d_s1 <= (reg_we && (reg_waddr == d_idx)) ? reg_wdata : regs[d_idx];
		rd_s_s1 <= (reg_we && (reg_waddr == s_idx)) ? reg_wdata : regs[s_idx];
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mrd_s1 <= (mem_we && (mem_waddr == a_idx)) ? mem_wdata : mem[a_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			value_q  <= ex_value;
			status_q <= ex_status;
		end
	end

	assign strobe = strobe_q;
	assign value  = value_q;
	assign status = status_q;

endmodule

[design/rvx_exec.sv]
// Instruction execution logic: result value, status and write-back controls for one command.
module rvx_exec (
	input  logic [rvx_pkg::CMD_W-1:0]    cmd,
	input  rvx_pkg::word_t               immediate,
	input  rvx_pkg::word_t               reg_d,
	input  rvx_pkg::word_t               reg_s,
	input  rvx_pkg::word_t               mem_rd,
	output rvx_pkg::word_t               value,
	output logic [rvx_pkg::STATUS_W-1:0] status,
	output rvx_pkg::wb_t                 wb
);

	logic [rvx_pkg::WORD_W:0] sum;

	assign sum = {1'b0, reg_d} + {1'b0, reg_s};

	always_comb begin
		value         = '0;
		status        = rvx_pkg::ST_SILENT;
		wb.reg_we     = 1'b0;
		wb.reg_wdata  = reg_s;
		wb.mem_we     = 1'b0;
		wb.mem_wdata  = reg_s;
		unique case (cmd)
			rvx_pkg::CMD_ADD: begin
				if (sum[rvx_pkg::WORD_W]) begin
					status = rvx_pkg::ST_OVERFLOW;
				end else begin
					wb.reg_we    = 1'b1;
					wb.reg_wdata = sum[rvx_pkg::WORD_W-1:0];
					value        = sum[rvx_pkg::WORD_W-1:0];
					status       = rvx_pkg::ST_VALID;
				end
			end
			rvx_pkg::CMD_MOVE_REG: begin
				wb.reg_we    = 1'b1;
				wb.reg_wdata = reg_s;
			end
			rvx_pkg::CMD_MOVE_IMM: begin
				wb.reg_we    = 1'b1;
				wb.reg_wdata = immediate;
			end
			rvx_pkg::CMD_LOAD: begin
				wb.reg_we    = 1'b1;
				wb.reg_wdata = mem_rd;
			end
			rvx_pkg::CMD_STORE: begin
				wb.mem_we    = 1'b1;
				wb.mem_wdata = reg_s;
			end
			rvx_pkg::CMD_READ_REG: begin
				value  = reg_d;
				status = rvx_pkg::ST_VALID;
			end
			rvx_pkg::CMD_READ_MEM: begin
				value  = mem_rd;
				status = rvx_pkg::ST_VALID;
			end
			default: begin
				value  = '0;
				status = rvx_pkg::ST_SILENT;
			end
		endcase
	end

endmodule

[tb/tb_register_vm_execute_unit.sv]
`timescale 1ns / 100ps
// Self-checking testbench for the register VM execute unit, checked against its own shadow model.
module tb_register_vm_execute_unit;

	localparam int REG_COUNT = rvx_pkg::NUM_REGS_DEF;
	localparam int MEM_COUNT = rvx_pkg::MEM_WORDS_DEF;
	localparam logic [rvx_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;
	localparam int MAX_REPORTS = 10;

	typedef logic [rvx_pkg::CMD_W-1:0]      cmd_t;
	typedef logic [rvx_pkg::REG_FLD_W-1:0]  reg_fld_t;
	typedef logic [rvx_pkg::ADDR_FLD_W-1:0] addr_t;

	typedef struct packed {
		rvx_pkg::word_t                 value;
		logic [rvx_pkg::STATUS_W-1:0]   status;
	} exec_result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	cmd_t                           cmd;
	reg_fld_t                       dest_reg;
	reg_fld_t                       src_reg;
	addr_t                          mem_addr;
	rvx_pkg::word_t                 immediate;
	logic                           strobe;
	rvx_pkg::word_t                 value;
	logic [rvx_pkg::STATUS_W-1:0]   status;

	rvx_pkg::word_t reg_shadow[REG_COUNT];
	rvx_pkg::word_t mem_shadow[MEM_COUNT];
	exec_result_t   pending_results[$];
	int unsigned    mismatch_count;

	register_vm_execute_unit #(
		.NUM_REGS  (REG_COUNT),
		.MEM_WORDS (MEM_COUNT)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.dest_reg  (dest_reg),
		.src_reg   (src_reg),
		.mem_addr  (mem_addr),
		.immediate (immediate),
		.strobe    (strobe),
		.value     (value),
		.status    (status)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic void note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS) begin
			$display("%0t: %s", $time, msg);
		end
	endfunction

	// Applies one command to the shadow state and queues the result it must give.
	function automatic void execute_shadow(input cmd_t op,
			input reg_fld_t dr, input reg_fld_t sr,
			input addr_t addr, input rvx_pkg::word_t imm);
		int unsigned              d;
		int unsigned              s;
		int unsigned              a;
		logic [rvx_pkg::WORD_W:0] sum;
		exec_result_t             res;
		d = dr % REG_COUNT;
		s = sr % REG_COUNT;
		a = addr % MEM_COUNT;
		res.value = '0;
		res.status = rvx_pkg::ST_SILENT;
		unique case (op)
			rvx_pkg::CMD_ADD: begin
				sum = {1'b0, reg_shadow[d]} + {1'b0, reg_shadow[s]};
				if (sum[rvx_pkg::WORD_W]) begin
					res.status = rvx_pkg::ST_OVERFLOW;
				end else begin
					reg_shadow[d] = sum[rvx_pkg::WORD_W-1:0];
					res.value = sum[rvx_pkg::WORD_W-1:0];
					res.status = rvx_pkg::ST_VALID;
				end
			end
			rvx_pkg::CMD_MOVE_REG: reg_shadow[d] = reg_shadow[s];
			rvx_pkg::CMD_MOVE_IMM: reg_shadow[d] = imm;
			rvx_pkg::CMD_LOAD: reg_shadow[d] = mem_shadow[a];
			rvx_pkg::CMD_STORE: mem_shadow[a] = reg_shadow[s];
			rvx_pkg::CMD_READ_REG: begin
				res.value = reg_shadow[d];
				res.status = rvx_pkg::ST_VALID;
			end
			rvx_pkg::CMD_READ_MEM: begin
				res.value = mem_shadow[a];
				res.status = rvx_pkg::ST_VALID;
			end
			default: ;
		endcase
		pending_results.push_back(res);
	endfunction

	// Called just after a rising edge; returns at the edge that accepts the transaction.
	task automatic send_command(input cmd_t op, input reg_fld_t dr,
			input reg_fld_t sr, input addr_t addr, input rvx_pkg::word_t imm);
		start <= 1'b1;
		cmd <= op;
		dest_reg <= dr;
		src_reg <= sr;
		mem_addr <= addr;
		immediate <= imm;
		do @(posedge clk); while (busy);
		execute_shadow(op, dr, sr, addr, imm);
	endtask

	task automatic idle_cycles(input int unsigned n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	task automatic maybe_idle();
		if ($urandom_range(0, 3) == 0) begin
			idle_cycles($urandom_range(1, 10));
		end
	endtask

	function automatic addr_t pick_addr();
		if ($urandom_range(0, 1) == 0) begin
			return addr_t'($urandom_range(0, 7));
		end
		return addr_t'($urandom_range(0, 255));
	endfunction

	function automatic reg_fld_t pick_reg();
		return reg_fld_t'($urandom_range(0, 15));
	endfunction

	function automatic rvx_pkg::word_t pick_word(input int unsigned hi);
		return rvx_pkg::word_t'($urandom_range(0, hi));
	endfunction

	task automatic send_random_command();
		send_command(cmd_t'($urandom_range(0, 7)), pick_reg(), pick_reg(),
			pick_addr(), pick_word(16'hFFFF));
	endtask

	always @(posedge clk) begin : check_results
		exec_result_t want;
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				note_mismatch($sformatf("unexpected transaction: value %h status %0d",
					value, status));
			end else begin
				want = pending_results.pop_front();
				if (value !== want.value) begin
					note_mismatch($sformatf("value mismatch: expected %h, got %h",
						want.value, value));
				end
				if (status !== want.status) begin
					note_mismatch($sformatf("status mismatch: expected %0d, got %0d",
						want.status, status));
				end
			end
		end
	end

	task automatic test_directed();
		send_command(rvx_pkg::CMD_READ_REG, 4'd0, 4'd0, 8'd0, 16'h0000);
		send_command(rvx_pkg::CMD_READ_MEM, 4'd0, 4'd0, 8'd255, 16'h0000);
		maybe_idle();
		send_command(rvx_pkg::CMD_MOVE_IMM, 4'd15, 4'd0, 8'd0, 16'hFFFF);
		send_command(rvx_pkg::CMD_MOVE_IMM, 4'd0, 4'd15, 8'd0, 16'h0001);
		send_command(rvx_pkg::CMD_ADD, 4'd15, 4'd0, 8'd0, 16'h0000);
		send_command(rvx_pkg::CMD_READ_REG, 4'd15, 4'd0, 8'd0, 16'h0000);
		maybe_idle();
		send_command(rvx_pkg::CMD_MOVE_IMM, 4'd1, 4'd0, 8'd0, 16'hFFFE);
		send_command(rvx_pkg::CMD_ADD, 4'd1, 4'd0, 8'd0, 16'h0000);
		send_command(rvx_pkg::CMD_ADD, 4'd2, 4'd2, 8'd0, 16'h0000);
		send_command(rvx_pkg::CMD_MOVE_REG, 4'd3, 4'd15, 8'd0, 16'h0000);
		send_command(rvx_pkg::CMD_STORE, 4'd0, 4'd3, 8'd255, 16'h0000);
		send_command(rvx_pkg::CMD_STORE, 4'd0, 4'd0, 8'd0, 16'h0000);
		maybe_idle();
		send_command(rvx_pkg::CMD_LOAD, 4'd4, 4'd0, 8'd255, 16'h0000);
		send_command(rvx_pkg::CMD_READ_REG, 4'd4, 4'd0, 8'd0, 16'h0000);
		send_command(rvx_pkg::CMD_READ_MEM, 4'd0, 4'd0, 8'd0, 16'h0000);
		send_command(CMD_UNUSED, 4'd15, 4'd15, 8'd255, 16'hFFFF);
		send_command(rvx_pkg::CMD_READ_REG, 4'd15, 4'd0, 8'd0, 16'h0000);
		send_command(rvx_pkg::CMD_MOVE_IMM, 4'd5, 4'd0, 8'd0, 16'hA5A5);
		send_command(rvx_pkg::CMD_ADD, 4'd5, 4'd5, 8'd0, 16'h0000);
		send_command(rvx_pkg::CMD_READ_REG, 4'd5, 4'd0, 8'd0, 16'h0000);
		send_command(rvx_pkg::CMD_READ_MEM, 4'd0, 4'd0, 8'd128, 16'h0000);
		maybe_idle();
	endtask

	task automatic test_random_mix(input int unsigned count);
		repeat (count) begin
			send_random_command();
			maybe_idle();
		end
	endtask

	// Each sequence sets two registers, adds them and moves the outcome through memory.
	task automatic test_dataflow_sequences(input int unsigned count);
		reg_fld_t ra;
		reg_fld_t rb;
		reg_fld_t rc;
		addr_t    addr;
		repeat (count) begin
			ra = pick_reg();
			rb = pick_reg();
			rc = pick_reg();
			addr = pick_addr();
			send_command(rvx_pkg::CMD_MOVE_IMM, ra, pick_reg(), pick_addr(),
				pick_word(16'hFFFF));
			maybe_idle();
			send_command(rvx_pkg::CMD_MOVE_IMM, rb, pick_reg(), pick_addr(),
				pick_word(16'h7FFF));
			maybe_idle();
			send_command(rvx_pkg::CMD_ADD, ra, rb, pick_addr(), pick_word(16'hFFFF));
			maybe_idle();
			send_command(rvx_pkg::CMD_STORE, pick_reg(), ra, addr, pick_word(16'hFFFF));
			maybe_idle();
			send_command(rvx_pkg::CMD_LOAD, rc, pick_reg(), addr, pick_word(16'hFFFF));
			maybe_idle();
			send_command(rvx_pkg::CMD_READ_REG, rc, pick_reg(), pick_addr(),
				pick_word(16'hFFFF));
			maybe_idle();
			send_command(rvx_pkg::CMD_READ_MEM, pick_reg(), pick_reg(), addr,
				pick_word(16'hFFFF));
			maybe_idle();
		end
	endtask

	task automatic test_back_to_back(input int unsigned count);
		repeat (count) begin
			send_random_command();
		end
	endtask

	task automatic drain_and_report();
		int unsigned waited;
		start <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 1000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		if (pending_results.size() != 0) begin
			note_mismatch($sformatf("%0d transactions never came back",
				pending_results.size()));
		end
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	endtask

	initial begin
		mismatch_count = 0;
		foreach (reg_shadow[i]) reg_shadow[i] = '0;
		foreach (mem_shadow[i]) mem_shadow[i] = '0;
		arst_n <= 1'b0;
		start <= 1'b0;
		cmd <= rvx_pkg::CMD_ADD;
		dest_reg <= '0;
		src_reg <= '0;
		mem_addr <= '0;
		immediate <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_mix(800);
		test_dataflow_sequences(100);
		test_back_to_back(400);
		drain_and_report();
	end

endmodule

[files.f]
design/rvx_pkg.sv
design/rvx_exec.sv
design/register_vm_execute_unit.sv
tb/tb_register_vm_execute_unit.sv
